@@ rtl/spq_pkg.sv @@
// Shared widths, operation codes, register indexes and helpers of the scale pitch quantizer.
package spq_pkg;

    localparam int VALUE_W   = 10;
    localparam int RESULT_W  = 12;
    localparam int MASK_W    = 64;
    localparam int PPO_W     = 7;
    localparam int ROOT_W    = 6;
    localparam int DIV_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam int DEFAULT_MAX_PPO = 64;
    localparam logic [PPO_W-1:0] PPO_RESET = 7'd12;

    localparam int TONE_CAP   = 998;
    localparam int RESULT_MAX = 2047;
    localparam int RESULT_MIN = -2048;

    localparam int MINOR_THIRD   = 3;
    localparam int FOURTH        = 5;
    localparam int FIFTH         = 7;
    localparam int MINOR_SEVENTH = 10;
    localparam int MAJOR_SECOND  = 2;
    localparam int MAJOR_THIRD   = 4;
    localparam int MAJOR_SIXTH   = 9;

    typedef logic [2:0] func_t;

    localparam func_t FUNC_QUANTIZE      = 3'd0;
    localparam func_t FUNC_IN_SCALE      = 3'd1;
    localparam func_t FUNC_IN_PENTATONIC = 3'd2;
    localparam func_t FUNC_TONE_TO_PITCH = 3'd3;
    localparam func_t FUNC_PITCH_TO_TONE = 3'd4;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_PPO  = 2'd0;
    localparam cfg_idx_t CFG_ROOT = 2'd1;
    localparam cfg_idx_t CFG_MASK = 2'd2;

    function automatic logic is_penta_class(input logic minor, input logic [7:0] c);
        logic hit;
        if (minor)
        begin
            hit = (c == 8'd0) || (c == 8'(MINOR_THIRD)) || (c == 8'(FOURTH)) ||
                  (c == 8'(FIFTH)) || (c == 8'(MINOR_SEVENTH));
        end
        else
        begin
            hit = (c == 8'd0) || (c == 8'(MAJOR_SECOND)) || (c == 8'(MAJOR_THIRD)) ||
                  (c == 8'(FIFTH)) || (c == 8'(MAJOR_SIXTH));
        end
        return hit;
    endfunction

endpackage

@@ rtl/scale_pitch_quantizer_core.sv @@
// Scale pitch quantizer core: sequencer over a shared divider, mask walker and multiplier.
// Quantize, membership and pitch to tone divide twice and walk the scale mask once; tone to
// pitch walks it twice, with a division before each walk; unused codes divide once, no walk.
// A new transaction is accepted only in idle, after the last result has entered the output
// register; the walk over the scale mask and the 12-step divider set the pace. Reset gives
// 12 pitches per octave, root 0 and a chromatic scale; no result is pending after reset.
module scale_pitch_quantizer_core
    import spq_pkg::*;
#(
    parameter int MAX_PITCHES_PER_OCTAVE = DEFAULT_MAX_PPO
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  func_t                      func,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [RESULT_W-1:0] result_value,
    output logic                       flag,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  cfg_idx_t                   cfg_index,
    input  logic [MASK_W-1:0]          cfg_data
);

    localparam int PW  = $clog2(MAX_PITCHES_PER_OCTAVE + 1);
    localparam int PRW = DIV_W + PW + 2;
    localparam int SW  = PRW + 1;
    localparam logic [7:0] MAX_P8  = 8'(MAX_PITCHES_PER_OCTAVE);
    localparam logic [7:0] MASK_W8 = 8'(MASK_W);
    localparam logic signed [DIV_W-1:0] MINUS_ONE = '1;
    localparam logic signed [SW-1:0] SAT_HI  = SW'(RESULT_MAX);
    localparam logic signed [SW-1:0] SAT_LO  = SW'(RESULT_MIN);
    localparam logic signed [SW-1:0] CAP_TON = SW'(TONE_CAP);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROOT  = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_WALK1 = 4'd3;
    localparam logic [3:0] S_DIV2  = 4'd4;
    localparam logic [3:0] S_WALK2 = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_ADD   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [PPO_W-1:0]  ppo_reg;
    logic [ROOT_W-1:0] rootp_reg;
    logic [MASK_W-1:0] mask_reg;

    logic [3:0]                 state_reg, state_next;
    func_t                      func_reg, func_next;
    logic signed [VALUE_W-1:0]  val_reg, val_next;
    logic [PW-1:0]              root_reg, root_next;
    logic signed [DIV_W-1:0]    quo_reg, quo_next;
    logic [PW-1:0]              tgt_reg, tgt_next;
    logic [PW-1:0]              t_reg, t_next;
    logic [PW-1:0]              k_reg, k_next;
    logic [MASK_W-1:0]          msh_reg, msh_next;
    logic [PW-1:0]              cnt_reg, cnt_next;
    logic [PW-1:0]              lt_reg, lt_next;
    logic [PW-1:0]              best_reg, best_next;
    logic [PW-1:0]              hi_reg, hi_next;
    logic [PW-1:0]              deg_reg, deg_next;
    logic                       found_reg, found_next;
    logic                       atc_reg, atc_next;
    logic                       at3_reg, at3_next;
    logic signed [PRW-1:0]      prod_reg, prod_next;
    logic signed [RESULT_W-1:0] res_reg, res_next;
    logic                       flg_reg, flg_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [RESULT_W-1:0] out_res_reg, out_res_next;
    logic                       out_flag_reg, out_flag_next;

    logic [7:0]        p8;
    logic [7:0]        last8;
    logic [7:0]        three8;
    logic [PW-1:0]     p;
    logic [PW-1:0]     walk_last;
    logic [PW-1:0]     three;
    logic [MASK_W-1:0] eff_mask;
    logic              chromatic;

    logic                    div_start;
    logic signed [DIV_W-1:0] div_dividend;
    logic [PW-1:0]           div_divisor;
    logic                    div_done;
    logic signed [DIV_W-1:0] div_quot;
    logic [PW-1:0]           div_rem;

    logic          bit_set;
    logic [PW-1:0] w_cnt;
    logic [PW-1:0] w_lt;
    logic [PW-1:0] w_best;
    logic [PW-1:0] w_hi;
    logic [PW-1:0] w_deg;
    logic          w_found;
    logic          w_atc;
    logic          w_at3;

    logic signed [DIV_W:0]  quo_ext;
    logic signed [DIV_W:0]  mul_a;
    logic [PW-1:0]          mul_b;
    logic [PW-1:0]          add_term;
    logic signed [SW-1:0]   sum;
    logic signed [SW-1:0]   sat;
    logic                   in_sc;
    logic                   minor;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppo_reg   <= PPO_RESET;
            rootp_reg <= '0;
            mask_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PPO:  ppo_reg   <= cfg_data[PPO_W-1:0];
                CFG_ROOT: rootp_reg <= cfg_data[ROOT_W-1:0];
                CFG_MASK: mask_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        if (ppo_reg == '0)
        begin
            p8 = 8'd1;
        end
        else if ({1'b0, ppo_reg} > MAX_P8)
        begin
            p8 = MAX_P8;
        end
        else
        begin
            p8 = {1'b0, ppo_reg};
        end
        last8 = ((p8 > MASK_W8) ? MASK_W8 : p8) - 8'd1;
        if (p8 > 8'(MINOR_THIRD))
        begin
            three8 = 8'(MINOR_THIRD);
        end
        else if (p8 == 8'd2)
        begin
            three8 = 8'd1;
        end
        else
        begin
            three8 = 8'd0;
        end
        for (int i = 0; i < MASK_W; i++)
        begin
            eff_mask[i] = mask_reg[i] & (8'(i) < p8);
        end
    end

    assign p         = PW'(p8);
    assign walk_last = PW'(last8);
    assign three     = PW'(three8);
    assign chromatic = (eff_mask == '0);

    spq_div #(
        .PW (PW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        bit_set = msh_reg[0];
        w_cnt   = cnt_reg;
        w_lt    = lt_reg;
        w_best  = best_reg;
        w_hi    = hi_reg;
        w_deg   = deg_reg;
        w_found = found_reg;
        w_atc   = atc_reg;
        w_at3   = at3_reg;
        if (bit_set)
        begin
            w_cnt = cnt_reg + 1'b1;
            w_hi  = k_reg;
            if (k_reg < tgt_reg)
            begin
                w_lt = lt_reg + 1'b1;
            end
            if (k_reg <= tgt_reg)
            begin
                w_best  = k_reg;
                w_found = 1'b1;
            end
            if (k_reg == tgt_reg)
            begin
                w_atc = 1'b1;
            end
            if (k_reg == three)
            begin
                w_at3 = 1'b1;
            end
            if (cnt_reg == tgt_reg)
            begin
                w_deg = k_reg;
            end
        end
    end

    always_comb
    begin
        quo_ext = (DIV_W + 1)'(quo_reg);
        mul_a   = '0;
        mul_b   = p;
        unique case (func_reg)
            FUNC_QUANTIZE:      mul_a = found_reg ? quo_ext : quo_ext - 1'b1;
            FUNC_TONE_TO_PITCH: mul_a = quo_ext;
            FUNC_PITCH_TO_TONE:
            begin
                mul_a = quo_reg[DIV_W-1] ? '0 : quo_ext;
                mul_b = t_reg;
            end
            default:            mul_a = '0;
        endcase
    end

    always_comb
    begin
        unique case (func_reg)
            FUNC_QUANTIZE:      add_term = found_reg ? best_reg : hi_reg;
            FUNC_TONE_TO_PITCH: add_term = chromatic ? tgt_reg : deg_reg;
            default:            add_term = lt_reg;
        endcase
        if (func_reg == FUNC_PITCH_TO_TONE)
        begin
            sum = SW'(prod_reg) + $signed(SW'(add_term));
        end
        else
        begin
            sum = SW'(prod_reg) + $signed(SW'(add_term)) + $signed(SW'(root_reg));
        end
        priority if (func_reg == FUNC_PITCH_TO_TONE && sum > CAP_TON)
        begin
            sat = CAP_TON;
        end
        else if (sum > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (sum < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = sum;
        end
        in_sc = chromatic | ((quo_reg >= MINUS_ONE) & atc_reg);
        minor = chromatic | at3_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        val_next       = val_reg;
        root_next      = root_reg;
        quo_next       = quo_reg;
        tgt_next       = tgt_reg;
        t_next         = t_reg;
        k_next         = k_reg;
        msh_next       = msh_reg;
        cnt_next       = cnt_reg;
        lt_next        = lt_reg;
        best_next      = best_reg;
        hi_next        = hi_reg;
        deg_next       = deg_reg;
        found_next     = found_reg;
        atc_next       = atc_reg;
        at3_next       = at3_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        flg_next       = flg_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_res_next   = out_res_reg;
        out_flag_next  = out_flag_reg;
        div_start      = 1'b0;
        div_dividend   = DIV_W'(val_reg);
        div_divisor    = p;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next    = func;
                    val_next     = value;
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(rootp_reg);
                    state_next   = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (div_done)
                begin
                    root_next = div_rem;
                    if (func_reg == FUNC_TONE_TO_PITCH)
                    begin
                        k_next     = '0;
                        msh_next   = eff_mask;
                        cnt_next   = '0;
                        lt_next    = '0;
                        found_next = 1'b0;
                        atc_next   = 1'b0;
                        at3_next   = 1'b0;
                        state_next = S_WALK1;
                    end
                    else if (func_reg > FUNC_PITCH_TO_TONE)
                    begin
                        res_next   = '0;
                        flg_next   = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(val_reg) - DIV_W'(div_rem);
                        state_next   = S_DIV1;
                    end
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    quo_next   = div_quot;
                    tgt_next   = div_rem;
                    k_next     = '0;
                    msh_next   = eff_mask;
                    cnt_next   = '0;
                    lt_next    = '0;
                    found_next = 1'b0;
                    atc_next   = 1'b0;
                    at3_next   = 1'b0;
                    state_next = S_WALK1;
                end
            end
            S_WALK1, S_WALK2:
            begin
                k_next     = k_reg + 1'b1;
                msh_next   = msh_reg >> 1;
                cnt_next   = w_cnt;
                lt_next    = w_lt;
                best_next  = w_best;
                hi_next    = w_hi;
                deg_next   = w_deg;
                found_next = w_found;
                atc_next   = w_atc;
                at3_next   = w_at3;
                if (k_reg == walk_last)
                begin
                    if (state_reg == S_WALK2)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        t_next = (w_cnt == '0) ? p : w_cnt;
                        if (func_reg == FUNC_TONE_TO_PITCH)
                        begin
                            div_start    = 1'b1;
                            div_divisor  = (w_cnt == '0) ? p : w_cnt;
                            state_next   = S_DIV2;
                        end
                        else
                        begin
                            state_next = S_MUL;
                        end
                    end
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    quo_next   = div_quot;
                    tgt_next   = div_rem;
                    k_next     = '0;
                    msh_next   = eff_mask;
                    cnt_next   = '0;
                    state_next = S_WALK2;
                end
            end
            S_MUL:
            begin
                prod_next  = mul_a * $signed({1'b0, mul_b});
                state_next = S_ADD;
            end
            S_ADD:
            begin
                res_next = '0;
                flg_next = 1'b0;
                unique case (func_reg)
                    FUNC_QUANTIZE, FUNC_PITCH_TO_TONE:
                    begin
                        res_next = chromatic ? RESULT_W'(val_reg) : sat[RESULT_W-1:0];
                    end
                    FUNC_IN_SCALE:
                    begin
                        flg_next = in_sc;
                    end
                    FUNC_IN_PENTATONIC:
                    begin
                        flg_next = in_sc & is_penta_class(minor, 8'(tgt_reg));
                    end
                    FUNC_TONE_TO_PITCH:
                    begin
                        res_next = sat[RESULT_W-1:0];
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_flag_next  = flg_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        val_reg      <= val_next;
        root_reg     <= root_next;
        quo_reg      <= quo_next;
        tgt_reg      <= tgt_next;
        t_reg        <= t_next;
        k_reg        <= k_next;
        msh_reg      <= msh_next;
        cnt_reg      <= cnt_next;
        lt_reg       <= lt_next;
        best_reg     <= best_next;
        hi_reg       <= hi_next;
        deg_reg      <= deg_next;
        found_reg    <= found_next;
        atc_reg      <= atc_next;
        at3_reg      <= at3_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        flg_reg      <= flg_next;
        out_res_reg  <= out_res_next;
        out_flag_reg <= out_flag_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = out_res_reg;
    assign flag         = out_flag_reg;

endmodule

@@ rtl/spq_div.sv @@
// Bit-serial restoring divider with floor quotient and floor remainder.
module spq_div
    import spq_pkg::*;
#(
    parameter int PW = 7
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] dividend,
    input  logic [PW-1:0]           divisor,
    output logic                    done,
    output logic signed [DIV_W-1:0] quotient,
    output logic [PW-1:0]           remainder
);

    localparam int CW = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [DIV_W-1:0] mag_reg, mag_next;
    logic [PW-1:0]    rem_reg, rem_next;
    logic [PW-1:0]    dvs_reg, dvs_next;

    logic [PW:0]      shifted;
    logic [PW:0]      diff;
    logic             fits;
    logic [DIV_W-1:0] abs_in;
    logic [DIV_W-1:0] q_mag;

    assign shifted = {rem_reg, mag_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign abs_in  = dividend[DIV_W-1] ? $unsigned(-dividend) : $unsigned(dividend);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[DIV_W-1];
            mag_next  = abs_in;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[PW-1:0] : shifted[PW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            q_mag     = mag_reg;
            remainder = rem_reg;
        end
        else if (rem_reg != '0)
        begin
            q_mag     = ~mag_reg;
            remainder = dvs_reg - rem_reg;
        end
        else
        begin
            q_mag     = -mag_reg;
            remainder = rem_reg;
        end
    end

    assign quotient = $signed(q_mag);
    assign done     = done_reg;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the scale pitch quantizer core, with its own scale predictor.
module tb_top;
    import spq_pkg::*;

    localparam int MAX_PPO        = DEFAULT_MAX_PPO;
    localparam int PPO_TOP        = (1 << PPO_W) - 1;
    localparam int RANDOM_PHASES  = 15;
    localparam int PHASE_QUERIES  = 30;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int END_HOLD       = 200;

    localparam func_t FUNC_SPARE_FIRST = 3'd5;
    localparam func_t FUNC_SPARE_LAST  = 3'd7;

    localparam logic [MASK_W-1:0] MAJOR_MASK = 64'h0000_0000_0000_0AB5;
    localparam logic [MASK_W-1:0] MINOR_MASK = 64'h0000_0000_0000_05AD;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result_value;
        logic                       flag;
    } answer_t;

    typedef struct {
        func_t                      func;
        logic signed [VALUE_W-1:0]  value;
    } query_t;

    typedef struct {
        cfg_idx_t                   index;
        logic [MASK_W-1:0]          data;
    } reg_write_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    func_t                      func = FUNC_QUANTIZE;
    logic signed [VALUE_W-1:0]  value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [RESULT_W-1:0] result_value;
    logic                       flag;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    cfg_idx_t                   cfg_index = CFG_PPO;
    logic [MASK_W-1:0]          cfg_data = '0;

    logic [PPO_W-1:0]  cur_ppo = PPO_RESET;
    logic [ROOT_W-1:0] cur_root = '0;
    logic [MASK_W-1:0] cur_mask = '0;

    query_t     query_q[$];
    answer_t    answer_q[$];
    reg_write_t reg_q[$];

    query_t     next_query;
    reg_write_t next_write;
    answer_t    want;
    logic       no_idle = 1'b0;
    logic       failed = 1'b0;
    int         send_gap = 0;
    int         ready_hold = 0;
    int         idle_cycles = 0;

    scale_pitch_quantizer_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .flag         (flag),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int fdiv(input int a, input int b);
        int q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic int fmod(input int a, input int b);
        return a - fdiv(a, b) * b;
    endfunction

    function automatic logic in_key(input int v, input int p, input int root,
                                    input logic [MASK_W-1:0] m);
        int x;
        x = v - root + p;
        if (m == '0)
            return 1'b1;
        if (x < 0)
            return 1'b0;
        return m[x % p];
    endfunction

    function automatic int degree_at(input int idx, input int p, input logic [MASK_W-1:0] m);
        int n;
        int c;
        int cls;
        n = 0;
        cls = 0;
        if (m == '0)
            return idx;
        for (c = 0; c < p; c++)
        begin
            if (m[c])
            begin
                if (n == idx)
                    cls = c;
                n++;
            end
        end
        return cls;
    endfunction

    function automatic answer_t scale_answer(input func_t f, input int v);
        answer_t a;
        int p;
        int root;
        int t;
        int r;
        int o;
        int c;
        int k;
        int res;
        logic [MASK_W-1:0] m;
        p = int'(cur_ppo);
        if (p < 1)
            p = 1;
        if (p > MAX_PPO)
            p = MAX_PPO;
        root = int'(cur_root) % p;
        m = (p >= MASK_W) ? cur_mask : (cur_mask & ((64'd1 << p) - 64'd1));
        t = $countones(m);
        if (t == 0)
            t = p;
        res = 0;
        a.flag = 1'b0;
        case (f)
            FUNC_QUANTIZE:
            begin
                res = v;
                if (m != '0)
                begin
                    r = v - root;
                    o = fdiv(r, p);
                    c = fmod(r, p);
                    k = c;
                    while (k >= 0 && !m[k])
                        k--;
                    if (k >= 0)
                        res = o * p + k + root;
                    else
                    begin
                        k = p - 1;
                        while (k >= 0 && !m[k])
                            k--;
                        res = (o - 1) * p + k + root;
                    end
                end
            end
            FUNC_IN_SCALE:
                a.flag = in_key(v, p, root, m);
            FUNC_IN_PENTATONIC:
            begin
                if (in_key(v, p, root, m))
                begin
                    c = fmod(v - root, p);
                    if (in_key(root + MINOR_THIRD, p, root, m))
                        a.flag = (c == 0) || (c == MINOR_THIRD) || (c == FOURTH) ||
                                 (c == FIFTH) || (c == MINOR_SEVENTH);
                    else
                        a.flag = (c == 0) || (c == MAJOR_SECOND) || (c == MAJOR_THIRD) ||
                                 (c == FIFTH) || (c == MAJOR_SIXTH);
                end
            end
            FUNC_TONE_TO_PITCH:
                res = degree_at(fmod(v, t), p, m) + p * fdiv(v, t) + root;
            FUNC_PITCH_TO_TONE:
            begin
                res = v;
                if (m != '0)
                begin
                    r = v - root;
                    if (r < 0)
                        r = fmod(r, p);
                    o = r / p;
                    c = r % p;
                    res = (o + 1) * t;
                    for (k = t - 1; k >= 0; k--)
                        if (degree_at(k, p, m) >= c)
                            res = o * t + k;
                    if (res > TONE_CAP)
                        res = TONE_CAP;
                end
            end
            default:
                res = 0;
        endcase
        if (res > RESULT_MAX)
            res = RESULT_MAX;
        if (res < RESULT_MIN)
            res = RESULT_MIN;
        a.result_value = RESULT_W'(res);
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                answer_q = {answer_q, scale_answer(func, int'(value))};
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (query_q.size() != 0)
                begin
                    next_query = query_q.pop_front();
                    in_valid <= 1'b1;
                    func <= next_query.func;
                    value <= next_query.value;
                    send_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cur_ppo <= PPO_RESET;
            cur_root <= '0;
            cur_mask <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PPO:  cur_ppo <= cfg_data[PPO_W-1:0];
                    CFG_ROOT: cur_root <= cfg_data[ROOT_W-1:0];
                    CFG_MASK: cur_mask <= cfg_data;
                    default:  ;
                endcase
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_q.size() != 0)
                begin
                    next_write = reg_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= next_write.index;
                    cfg_data <= next_write.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_hold <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("unexpected transaction: result_value %0d, flag %0d",
                           result_value, flag);
                    failed <= 1'b1;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (result_value !== want.result_value)
                    begin
                        $error("result_value mismatch: expected %0d, actual %0d",
                               want.result_value, result_value);
                        failed <= 1'b1;
                    end
                    if (flag !== want.flag)
                    begin
                        $error("flag mismatch: expected %0d, actual %0d", want.flag, flag);
                        failed <= 1'b1;
                    end
                end
            end
            if (ready_hold != 0)
            begin
                out_ready <= 1'b0;
                ready_hold <= ready_hold - 1;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                ready_hold <= pick_gap();
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic drain();
        @(negedge clk);
        while (query_q.size() != 0 || in_valid || answer_q.size() != 0 ||
               reg_q.size() != 0 || cfg_valid)
            @(negedge clk);
    endtask

    task automatic set_scale(input int ppo, input int root, input logic [MASK_W-1:0] mask);
        reg_write_t w;
        drain();
        w.index = CFG_PPO;
        w.data = MASK_W'(ppo);
        reg_q = {reg_q, w};
        w.index = CFG_ROOT;
        w.data = MASK_W'(root);
        reg_q = {reg_q, w};
        w.index = CFG_MASK;
        w.data = mask;
        reg_q = {reg_q, w};
        drain();
    endtask

    task automatic push_query(input func_t f, input int v);
        query_t q;
        q.func = f;
        q.value = VALUE_W'(v);
        query_q = {query_q, q};
    endtask

    initial
    begin
        int ph;
        int n;
        int sel;
        int ppo;
        int live;
        int root;
        int v;
        func_t f;
        logic [MASK_W-1:0] mask;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset scale: twelve classes, root zero, chromatic.
        drain();
        push_query(FUNC_QUANTIZE, 511);
        push_query(FUNC_IN_SCALE, -512);
        push_query(FUNC_IN_PENTATONIC, 3);
        push_query(FUNC_TONE_TO_PITCH, -1);
        push_query(FUNC_PITCH_TO_TONE, 0);
        push_query(FUNC_SPARE_FIRST, 7);
        push_query(FUNC_SPARE_FIRST + 1, -1);
        push_query(FUNC_SPARE_LAST, 0);

        set_scale(12, 0, MAJOR_MASK);
        push_query(FUNC_QUANTIZE, 1);
        push_query(FUNC_QUANTIZE, -1);
        push_query(FUNC_IN_SCALE, 6);
        push_query(FUNC_IN_PENTATONIC, 4);
        push_query(FUNC_TONE_TO_PITCH, -8);
        push_query(FUNC_PITCH_TO_TONE, 6);

        // Oversized octave with the top class as the only degree; tone to pitch results saturate.
        set_scale(PPO_TOP, 63, 64'h8000_0000_0000_0000);
        push_query(FUNC_TONE_TO_PITCH, 511);
        push_query(FUNC_TONE_TO_PITCH, -512);
        push_query(FUNC_QUANTIZE, 0);
        push_query(FUNC_PITCH_TO_TONE, -512);

        // Root past the octave and a mask with no bit inside it.
        set_scale(5, 7, 64'h0000_0000_FFFF_FFE0);
        push_query(FUNC_QUANTIZE, -3);
        push_query(FUNC_PITCH_TO_TONE, -300);
        push_query(FUNC_IN_SCALE, 2);

        set_scale(0, 0, 64'h3);
        push_query(FUNC_TONE_TO_PITCH, -7);
        push_query(FUNC_QUANTIZE, 511);
        push_query(FUNC_IN_PENTATONIC, 0);

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                ppo = 12;
                root = $urandom_range(0, 11);
                sel = $urandom_range(0, 9);
                mask = (sel == 0) ? '0 : (sel < 5) ? MAJOR_MASK : MINOR_MASK;
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    ppo = $urandom_range(1, 24);
                else if (sel < 75)
                    ppo = MAX_PPO;
                else if (sel < 88)
                    ppo = $urandom_range(25, MAX_PPO - 1);
                else if (sel < 95)
                    ppo = $urandom_range(MAX_PPO + 1, PPO_TOP);
                else
                    ppo = 0;
                live = (ppo < 1) ? 1 : (ppo > MAX_PPO) ? MAX_PPO : ppo;
                root = ($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << ROOT_W) - 1)
                                                   : $urandom_range(0, live - 1);
                sel = $urandom_range(0, 99);
                if (sel < 15)
                    mask = '0;
                else if (sel < 45)
                    mask = {$urandom, $urandom};
                else if (sel < 75)
                    mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                else if (sel < 90)
                    mask = {$urandom, 32'h0};
                else
                    mask = '1;
            end
            no_idle = (ph % 5 == 3);
            set_scale(ppo, root, mask);
            for (n = 0; n < PHASE_QUERIES; n++)
            begin
                f = ($urandom_range(0, 24) == 0) ? func_t'($urandom_range(FUNC_SPARE_FIRST,
                                                                         FUNC_SPARE_LAST))
                                                 : func_t'($urandom_range(FUNC_QUANTIZE,
                                                                         FUNC_PITCH_TO_TONE));
                if ($urandom_range(0, 2) == 0)
                    v = $urandom_range(0, 80) - 40;
                else
                    v = $urandom_range(0, 1023) - 512;
                push_query(f, v);
            end
        end

        drain();
        repeat (END_HOLD) @(posedge clk);
        if (!failed && answer_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
